>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VALUE_W     = 16;
  localparam int PRIO_W      = 8;
  localparam int OUT_CNT_W   = 8;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_UPDATE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_INSERT,
    CMD_POP,
    CMD_REMOVE
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_REINS
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: compares against the broadcast key and moves its entry
// towards either neighbour.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    key,
  input  wire logic      occupied,
  input  wire logic      left_ins,
  input  wire entry_t    left_q,
  input  wire entry_t    right_q,
  output entry_t         q,
  output logic           ins,
  output logic           match
);

  // Free slots and slots of equal or lower priority sit behind the new entry
  assign ins   = !occupied || (key.prio >= q.prio);
  assign match = occupied && (q.value == key.value);

  always_ff @(posedge clk) begin
    if (ctl.insert && ins) begin
      q <= left_ins ? left_q : key;
    end else if (ctl.shift) begin
      q <= right_q;
    end
  end

endmodule
`default_nettype wire

>>> rtl/spq_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_chain
// Row of queue cells with the broadcast control and first-match search.
// ----------------------------------------------------------------------------
module spq_chain
  import spq_pkg::*;
(
  input  wire logic             clk,
  input  wire cmd_t             cmd,
  input  wire entry_t           key,
  input  wire logic [CNT_W-1:0] count,
  output entry_t                head,
  output logic                  found
);

  entry_t                 q     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ins;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] hit_upto;

  // Prefix OR: set at and after the first matching slot
  always_comb begin
    hit_upto = match;
    for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
      hit_upto = hit_upto | (hit_upto << s);
    end
  end

  assign found = hit_upto[QUEUE_DEPTH-1];
  assign head  = q[0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    logic      occupied;
    logic      left_ins;
    entry_t    left_q;
    entry_t    right_q;

    assign occupied   = CNT_W'(i) < count;
    assign ctl.insert = (cmd == CMD_INSERT);
    assign ctl.shift  = (cmd == CMD_POP) || ((cmd == CMD_REMOVE) && hit_upto[i]);

    if (i == 0) begin : g_first
      assign left_ins = 1'b0;
      assign left_q   = '0;
    end else begin : g_mid
      assign left_ins = ins[i-1];
      assign left_q   = q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_inner
      assign right_q = q[i+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key      (key),
      .occupied (occupied),
      .left_ins (left_ins),
      .left_q   (left_q),
      .right_q  (right_q),
      .q        (q[i]),
      .ins      (ins[i]),
      .match    (match[i])
    );
  end

endmodule
`default_nettype wire

>>> rtl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Priority queue of (value, priority) entries held sorted in a row of cells.
// ----------------------------------------------------------------------------
// The result is registered on the transfer, except for an update that finds
// its value, whose result follows its remove pass and then its re-insert.
// Throughput: one operation per cycle while the output is not stalled; an update that finds
// its value holds the input while the cell row runs its re-insert.
// Reset: rst clears the entry count, the sequencer and the output valid.
// Cell contents are not cleared; slots beyond the count are never read.
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // item_value[15:0], item_priority[23:16]
  input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // out_value[15:0], out_priority[23:16],
                                          // out_count[31:24]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  entry_t             hold_key;
  logic               out_valid, out_valid_next;
  status_t            out_status, out_status_next;
  entry_t             out_entry, out_entry_next;

  logic               xfer_in;
  logic               load_hold;
  op_t                op;
  entry_t             in_key;
  entry_t             key;
  cmd_t               cmd;
  entry_t             head;
  logic               found;
  logic               is_empty;
  logic               is_full;

  assign op           = op_t'(s_axis_tuser);
  assign in_key.value = s_axis_tdata[VALUE_W-1:0];
  assign in_key.prio  = s_axis_tdata[VALUE_W+PRIO_W-1:VALUE_W];

  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(QUEUE_DEPTH));

  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign xfer_in       = s_axis_tvalid && s_axis_tready;

  assign key = (state == S_REINS) ? hold_key : in_key;

  spq_chain u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .key   (key),
    .count (count),
    .head  (head),
    .found (found)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    cmd             = CMD_IDLE;
    load_hold       = 1'b0;
    out_valid_next  = out_valid && !m_axis_tready;
    out_status_next = out_status;
    out_entry_next  = out_entry;

    case (state)
      S_IDLE: begin
        if (xfer_in) begin
          out_valid_next  = 1'b1;
          out_status_next = ST_OK;
          out_entry_next  = '0;
          case (op)
            OP_INSERT: begin
              if (is_full) begin
                out_status_next = ST_FULL;
              end else begin
                cmd        = CMD_INSERT;
                count_next = count + 1'b1;
              end
            end
            OP_DEQUEUE, OP_PEEK: begin
              if (is_empty) begin
                out_status_next = ST_EMPTY;
              end else begin
                out_entry_next = head;
                if (op == OP_DEQUEUE) begin
                  cmd        = CMD_POP;
                  count_next = count - 1'b1;
                end
              end
            end
            OP_UPDATE: begin
              if (is_empty) begin
                out_status_next = ST_EMPTY;
              end else if (!found) begin
                out_status_next = ST_NOTFOUND;
              end else begin
                // drop the first match now, re-insert it next cycle
                cmd            = CMD_REMOVE;
                count_next     = count - 1'b1;
                load_hold      = 1'b1;
                out_valid_next = 1'b0;
                state_next     = S_REINS;
              end
            end
            default: begin
              out_status_next = ST_OK;
            end
          endcase
        end
      end
      S_REINS: begin
        cmd             = CMD_INSERT;
        count_next      = count + 1'b1;
        out_valid_next  = 1'b1;
        out_status_next = ST_OK;
        out_entry_next  = '0;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_entry  <= out_entry_next;
    if (load_hold) begin
      hold_key <= in_key;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {OUT_CNT_W'(count), out_entry.prio, out_entry.value};

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_priority_queue_core. Requests go in on the
// slave stream with random gaps, and the master side stalls at random. A
// shadow copy of the sorted entries predicts every response, and responses
// are compared in order, field by field.
// ----------------------------------------------------------------------------
import spq_pkg::*;

typedef struct {
  status_t          status;
  logic [15:0]      value;
  logic [7:0]       prio;
  logic [7:0]       count;
} pq_response_t;

class queue_scoreboard;
  logic [15:0]  shadow_val [QUEUE_DEPTH];
  logic [7:0]   shadow_pri [QUEUE_DEPTH];
  int           held = 0;
  pq_response_t due_responses [$];
  int           errors = 0;

  // Sorted insert: ahead of every entry of equal or lower priority.
  function void place(logic [15:0] v, logic [7:0] p);
    int pos;
    pos = held;
    while (pos > 0 && p >= shadow_pri[pos-1]) begin
      shadow_val[pos] = shadow_val[pos-1];
      shadow_pri[pos] = shadow_pri[pos-1];
      pos--;
    end
    shadow_val[pos] = v;
    shadow_pri[pos] = p;
    held++;
  endfunction

  function void remove_at(int idx);
    for (int i = idx; i + 1 < held; i++) begin
      shadow_val[i] = shadow_val[i+1];
      shadow_pri[i] = shadow_pri[i+1];
    end
    held--;
  endfunction

  // Pick a value currently held, so that updates mostly find their entry.
  function logic [15:0] held_value();
    if (held == 0)
      return 16'($urandom);
    return shadow_val[$urandom_range(0, held - 1)];
  endfunction

  function void take_request(op_t op, logic [15:0] v, logic [7:0] p);
    pq_response_t r;
    int           hit;
    r.status = ST_OK;
    r.value  = '0;
    r.prio   = '0;
    case (op)
      OP_INSERT: begin
        if (held >= QUEUE_DEPTH)
          r.status = ST_FULL;
        else
          place(v, p);
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = shadow_val[0];
          r.prio  = shadow_pri[0];
          if (op == OP_DEQUEUE)
            remove_at(0);
        end
      end
      default: begin
        hit = -1;
        for (int i = 0; i < held; i++) begin
          if (hit < 0 && shadow_val[i] == v)
            hit = i;
        end
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          remove_at(hit);
          place(v, p);
        end
      end
    endcase
    r.count = 8'(held);
    due_responses.push_back(r);
  endfunction

  function void compare(string field, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_response(status_t st, logic [15:0] v, logic [7:0] p,
                               logic [7:0] cnt);
    pq_response_t e;
    if (due_responses.size() == 0) begin
      $error("response with nothing outstanding: status %0d count %0d", st, cnt);
      errors++;
      return;
    end
    e = due_responses.pop_front();
    compare("status", e.status, st);
    compare("out_value", e.value, v);
    compare("out_priority", e.prio, p);
    compare("out_count", e.count, cnt);
  endfunction
endclass

module testbench;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // item_value[15:0], item_priority[23:16]
  logic [1:0]  s_axis_tuser = '0;  // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // out_value[15:0], out_priority[23:16],
                                   // out_count[31:24]
  logic [1:0]  m_axis_tuser;       // status[1:0]

  queue_scoreboard sb = new;
  bit              calm = 1'b0;

  sorted_priority_queue_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(op_t op, logic [15:0] v, logic [7:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p, v};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_request(op, v, p);
  endtask

  task automatic send_random(int mode);
    op_t         op;
    int          r;
    logic [15:0] v;
    logic [7:0]  p;
    r = $urandom_range(0, 99);
    case (mode)
      1:       op = (r < 85) ? OP_INSERT : (r < 90) ? OP_DEQUEUE :
                    (r < 95) ? OP_PEEK : OP_UPDATE;
      3:       op = (r < 15) ? OP_INSERT : (r < 85) ? OP_DEQUEUE :
                    (r < 92) ? OP_PEEK : OP_UPDATE;
      default: op = (r < 40) ? OP_INSERT : (r < 65) ? OP_DEQUEUE :
                    (r < 80) ? OP_PEEK : OP_UPDATE;
    endcase
    if (op == OP_UPDATE && $urandom_range(0, 9) < 7)
      v = sb.held_value();
    else if ($urandom_range(0, 1) == 0)
      v = 16'($urandom_range(0, 31));
    else
      v = 16'($urandom);
    // A coarse set of priorities gives plenty of ties.
    if ($urandom_range(0, 9) < 4)
      p = 8'($urandom_range(0, 3) * 85);
    else
      p = 8'($urandom);
    send_request(op, v, p);
  endtask

  // Result sink with random back-pressure.
  initial begin : sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_response(status_t'(m_axis_tuser), m_axis_tdata[15:0],
                        m_axis_tdata[23:16], m_axis_tdata[31:24]);
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue cases.
    send_request(OP_PEEK, 16'h0000, 8'h00);
    send_request(OP_DEQUEUE, 16'hFFFF, 8'hFF);
    send_request(OP_UPDATE, 16'h1234, 8'h40);
    // Field extremes, ties and a duplicate value.
    send_request(OP_INSERT, 16'h0000, 8'h00);
    send_request(OP_INSERT, 16'hFFFF, 8'hFF);
    send_request(OP_INSERT, 16'h1234, 8'h80);
    send_request(OP_INSERT, 16'h5555, 8'h80);
    send_request(OP_INSERT, 16'hAAAA, 8'h80);
    send_request(OP_INSERT, 16'h1234, 8'h10);
    send_request(OP_PEEK, 16'h0000, 8'h00);
    // Duplicate: only the copy nearest the head moves, ahead of the equal head.
    send_request(OP_UPDATE, 16'h1234, 8'hFF);
    send_request(OP_UPDATE, 16'hBEEF, 8'h01);
    send_request(OP_UPDATE, 16'h0000, 8'hFF);
    send_request(OP_UPDATE, 16'hFFFF, 8'h00);
    repeat (7) send_request(OP_DEQUEUE, 16'h0000, 8'h00);
    send_request(OP_UPDATE, 16'h0000, 8'h00);

    // Random part in phases: mixed, filling to full, mixed, draining to empty.
    for (int i = 0; i < 2000; i++) begin
      calm = ((i / 100) % 5 == 2);
      send_random((i / 250) % 4);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (sb.due_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due_responses.size() == 0) begin
      $display("[sorted_priority_queue_core] OK");
    end else begin
      $display("[sorted_priority_queue_core] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[sorted_priority_queue_core] ERROR");
    $finish;
  end

endmodule
